// ----- hdl/isqrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root package
// Shared constants for the pipelined 48-bit integer square root.
// ----------------------------------------------------------------------------
package isqrt_pkg;

   // Width of the root field on the result channel.
   localparam int ROOT_BITS = 24;

   // Root bits resolved by each pipeline stage.
   localparam int STAGE_ROUNDS = 2;

endpackage

// ----- hdl/isqrt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root channels
// Valid/ready interfaces for the radicand and root transactions.
// ----------------------------------------------------------------------------
interface isqrt_req_if #(
   parameter int RADICAND_BITS = 48
) ();
   logic                     valid;
   logic                     ready;
   logic [RADICAND_BITS-1:0] radicand;

   modport source (output valid, output radicand, input ready);
   modport sink   (input valid, input radicand, output ready);
endinterface

interface isqrt_rsp_if ();
   import isqrt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ROOT_BITS-1:0] root;

   modport source (output valid, output root, input ready);
   modport sink   (input valid, input root, output ready);
endinterface

// ----- hdl/isqrt_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root pipeline stage
// Resolves ROUNDS root bits by restoring bit-pair steps, then registers.
// ----------------------------------------------------------------------------
module isqrt_stage #(
   parameter int PAIR_COUNT = 24,
   parameter int ROUNDS     = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [2*PAIR_COUNT-1:0] in_rad,
   input  logic [PAIR_COUNT:0]     in_rem,
   input  logic [PAIR_COUNT-1:0]   in_root,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [2*PAIR_COUNT-1:0] out_rad,
   output logic [PAIR_COUNT:0]     out_rem,
   output logic [PAIR_COUNT-1:0]   out_root
);
   import isqrt_pkg::*;

   localparam int RAD_W  = 2 * PAIR_COUNT;
   localparam int REM_W  = PAIR_COUNT + 1;
   localparam int TRY_W  = PAIR_COUNT + 3;

   logic                  valid_ff;
   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [PAIR_COUNT-1:0] root_ff, root_in;

   // Each round brings down the next radicand pair and tries 4*root+1.
   always_comb begin
      logic [TRY_W-1:0] part;
      logic [TRY_W-1:0] trial;
      rad_in  = in_rad;
      rem_in  = in_rem;
      root_in = in_root;
      for (int i = 0; i < ROUNDS; i++) begin
         part  = {rem_in, rad_in[RAD_W-1 -: 2]};
         trial = {1'b0, root_in, 2'b01};
         if (part >= trial) begin
            part    = part - trial;
            root_in = (root_in << 1) | PAIR_COUNT'(1);
         end else begin
            root_in = root_in << 1;
         end
         rem_in = part[REM_W-1:0];
         rad_in = rad_in << 2;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule

// ----- hdl/integer_square_root_48bit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root, 48-bit radicand
// Pipelined bit-pair restoring square root returning floor(sqrt(radicand)).
// ----------------------------------------------------------------------------
// Usage:
// A radicand transaction enters on req_chan and one root transaction leaves
// on rsp_chan for each of them, in the same order. The root is the floor of
// the square root of the radicand, cut to its low 24 bits (this only matters
// when RADICAND_BITS is above 48).
// The datapath is a chain of registered stages, each resolving two root bits
// (the last stage fewer when the pair count is odd). The depth per stage is
// set by two dependent compare-and-subtract steps on a word of about 27 bits.
// A new radicand is accepted in every cycle, so the throughput is one
// transaction per clock while the receiver keeps rsp_chan.ready high.
// When the receiver stalls, each stage holds its contents and the stall
// backs up stage by stage; empty stages still take new work, so nothing is
// lost or repeated. The last stage register is the output register.
// Reset clears every stage valid bit; the stage data registers are not reset.
// ----------------------------------------------------------------------------
module integer_square_root_48bit #(
   parameter int RADICAND_BITS = 48
) (
   input  logic         clock,
   input  logic         reset,
   isqrt_req_if.sink    req_chan,
   isqrt_rsp_if.source  rsp_chan
);
   import isqrt_pkg::*;

   // The radicand is handled as whole pairs; an odd width gets a zero on top.
   localparam int PAIR_COUNT = (RADICAND_BITS + 1) / 2;
   localparam int RAD_W      = 2 * PAIR_COUNT;
   localparam int NUM_STAGES = (PAIR_COUNT + STAGE_ROUNDS - 1) / STAGE_ROUNDS;

   logic                  valid_chain [NUM_STAGES+1];
   logic                  ready_chain [NUM_STAGES+1];
   logic [RAD_W-1:0]      rad_chain   [NUM_STAGES+1];
   logic [PAIR_COUNT:0]   rem_chain   [NUM_STAGES+1];
   logic [PAIR_COUNT-1:0] root_chain  [NUM_STAGES+1];

   // Stage zero input: the radicand with an empty remainder and root.
   assign valid_chain[0]  = req_chan.valid;
   assign req_chan.ready  = ready_chain[0];
   assign rad_chain[0]    = RAD_W'(req_chan.radicand);
   assign rem_chain[0]    = '0;
   assign root_chain[0]   = '0;

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      // The final stage takes whatever pairs remain.
      localparam int LEFT   = PAIR_COUNT - s * STAGE_ROUNDS;
      localparam int ROUNDS = (LEFT < STAGE_ROUNDS) ? LEFT : STAGE_ROUNDS;

      isqrt_stage #(
         .PAIR_COUNT (PAIR_COUNT),
         .ROUNDS     (ROUNDS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[s]),
         .in_ready  (ready_chain[s]),
         .in_rad    (rad_chain[s]),
         .in_rem    (rem_chain[s]),
         .in_root   (root_chain[s]),
         .out_valid (valid_chain[s+1]),
         .out_ready (ready_chain[s+1]),
         .out_rad   (rad_chain[s+1]),
         .out_rem   (rem_chain[s+1]),
         .out_root  (root_chain[s+1])
      );
   end

   assign rsp_chan.valid          = valid_chain[NUM_STAGES];
   assign ready_chain[NUM_STAGES] = rsp_chan.ready;

   // Fit the full root into the result field: zero-extend or keep low bits.
   if (PAIR_COUNT >= ROOT_BITS) begin : g_root_cut
      assign rsp_chan.root = root_chain[NUM_STAGES][ROOT_BITS-1:0];
   end else begin : g_root_ext
      assign rsp_chan.root = ROOT_BITS'(root_chain[NUM_STAGES]);
   end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root testbench
// Sends 48-bit radicands through the pipelined square root and checks every
// returned root, in order, against a typed-in root or a bit-pair restoring model.
// ----------------------------------------------------------------------------
module tb_top;
   import isqrt_pkg::*;

   localparam int RADICAND_BITS  = 48;
   localparam int PIPE_LATENCY   = 12;
   localparam int RESET_CYCLES   = 10;
   localparam int TOTAL_ITEMS    = 800;
   localparam int QUIET_ITEMS    = 120;
   localparam int PRESSURE_FIRST = 180;
   localparam int PRESSURE_LAST  = 380;
   localparam int HOLD_AFTER     = 200;
   localparam int HOLD_CYCLES    = 80;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int REPORT_LIMIT   = 10;
   localparam int DIRECTED_COUNT = 19;

   // One row of the directed table. When known is set the root is typed in;
   // otherwise the model below supplies it.
   typedef struct packed {
      logic [RADICAND_BITS-1:0] radicand;
      logic                     known;
      logic [ROOT_BITS-1:0]     root;
   } sqrt_case_type;

   localparam sqrt_case_type DIRECTED_CASES [DIRECTED_COUNT] = '{
      '{48'h0000_0000_0000, 1'b1, 24'h00_0000},  // zero
      '{48'h0000_0000_0001, 1'b1, 24'h00_0001},
      '{48'h0000_0000_0002, 1'b1, 24'h00_0001},
      '{48'h0000_0000_0003, 1'b1, 24'h00_0001},  // just below a square
      '{48'h0000_0000_0004, 1'b1, 24'h00_0002},  // smallest nontrivial square
      '{48'h0000_0000_0008, 1'b1, 24'h00_0002},
      '{48'h0000_0000_0009, 1'b1, 24'h00_0003},
      '{48'h0000_0000_000F, 1'b1, 24'h00_0003},
      '{48'h0000_0000_0010, 1'b1, 24'h00_0004},
      '{48'h0000_00FF_FFFF, 1'b1, 24'h00_0FFF},
      '{48'h0000_0100_0000, 1'b1, 24'h00_1000},
      '{48'h3FFF_FFFF_FFFF, 1'b1, 24'h7F_FFFF},
      '{48'h4000_0000_0000, 1'b1, 24'h80_0000},
      '{48'h8000_0000_0000, 1'b0, 24'h00_0000},  // odd power of two
      '{48'hAAAA_AAAA_AAAA, 1'b0, 24'h00_0000},
      '{48'h5555_5555_5555, 1'b0, 24'h00_0000},
      '{48'hFFFF_FE00_0000, 1'b1, 24'hFF_FFFE},  // one below the largest square
      '{48'hFFFF_FE00_0001, 1'b1, 24'hFF_FFFF},  // largest 48-bit square
      '{48'hFFFF_FFFF_FFFF, 1'b1, 24'hFF_FFFF}   // all ones
   };

   logic clock = 1'b0;
   logic reset;

   isqrt_req_if #(.RADICAND_BITS(RADICAND_BITS)) req_chan ();
   isqrt_rsp_if                                  rsp_chan ();

   integer_square_root_48bit #(
      .RADICAND_BITS(RADICAND_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Roots still owed by the pipeline, oldest first.
   logic [ROOT_BITS-1:0] pending_roots [$];

   int  error_count        = 0;
   int  roots_checked      = 0;
   int  input_stall_cycles = 0;
   int  random_sent        = 0;
   bit  quiet_tail         = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Floor of the square root by the restoring method: two radicand bits
   // enter the remainder per round, most significant pair first, and the
   // trial subtrahend is the root so far with 01 appended. The remainder
   // never exceeds twice the root, so 28 bits hold it with room to spare.
   function automatic logic [ROOT_BITS-1:0] floor_sqrt(
      input logic [RADICAND_BITS-1:0] radicand
   );
      logic [27:0]          remainder;
      logic [27:0]          trial;
      logic [ROOT_BITS-1:0] root;
      int                   pair;
      remainder = '0;
      root      = '0;
      for (pair = RADICAND_BITS / 2 - 1; pair >= 0; pair--) begin
         remainder = {remainder[25:0], radicand[2*pair +: 2]};
         trial     = {2'b00, root, 2'b01};
         if (remainder >= trial) begin
            remainder = remainder - trial;
            root      = {root[ROOT_BITS-2:0], 1'b1};
         end else begin
            root      = {root[ROOT_BITS-2:0], 1'b0};
         end
      end
      return root;
   endfunction

   // Random radicands lean toward the interesting spots: exact squares, the
   // values just below them, short operands and tiny values, with plain
   // uniform values for the rest so that every input bit toggles.
   function automatic logic [RADICAND_BITS-1:0] random_radicand();
      logic [63:0]              wide;
      logic [RADICAND_BITS-1:0] base;
      logic [RADICAND_BITS-1:0] value;
      int unsigned              width;
      wide  = {$urandom(), $urandom()};
      base  = {24'd0, wide[ROOT_BITS-1:0]};
      width = $urandom_range(1, RADICAND_BITS);
      case ($urandom_range(0, 5))
         0, 1: value = wide[RADICAND_BITS-1:0];
         2:    value = base * base;
         3:    value = base * base - 1'b1;
         4:    value = base * base + (base << 1);  // largest value with this root
         default: begin
            if ($urandom_range(0, 1) == 0) begin
               value = wide[RADICAND_BITS-1:0] & ((48'd1 << width) - 1'b1);
            end else begin
               value = RADICAND_BITS'($urandom_range(0, 300));
            end
         end
      endcase
      return value;
   endfunction

   task automatic check_root(input logic [ROOT_BITS-1:0] actual);
      logic [ROOT_BITS-1:0] wanted;
      if (pending_roots.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("%0t: root transaction 0x%06h arrived with none outstanding",
                     $realtime, actual);
         end
      end else begin
         wanted = pending_roots.pop_front();
         roots_checked++;
         if (actual !== wanted) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("%0t: root mismatch on result %0d: expected 0x%06h, got 0x%06h",
                        $realtime, roots_checked, wanted, actual);
            end
         end
      end
   endtask

   // Sender. It owns reset and drives the radicand channel from time zero.
   // Each radicand is held on the channel until the pipeline takes it; the
   // root it should produce is queued at that edge. Idle bursts are skipped
   // inside the pressure window, so the sender keeps offering while the
   // receiver holds off, and in the quiet tail at the end of the run.
   initial begin : radicand_sender
      int                       item_index;
      int                       gap;
      logic [RADICAND_BITS-1:0] radicand;
      logic [ROOT_BITS-1:0]     root_wanted;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.radicand <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (item_index = 0; item_index < TOTAL_ITEMS; item_index++) begin
         if (item_index < DIRECTED_COUNT) begin
            radicand = DIRECTED_CASES[item_index].radicand;
            if (DIRECTED_CASES[item_index].known) begin
               root_wanted = DIRECTED_CASES[item_index].root;
            end else begin
               root_wanted = floor_sqrt(radicand);
            end
         end else begin
            radicand    = random_radicand();
            root_wanted = floor_sqrt(radicand);
            random_sent++;
         end

         quiet_tail = (item_index >= TOTAL_ITEMS - QUIET_ITEMS);
         if (!quiet_tail
             && (item_index < PRESSURE_FIRST || item_index > PRESSURE_LAST)
             && $urandom_range(0, 7) == 0) begin
            req_chan.valid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge clock);
         end

         req_chan.valid    <= 1'b1;
         req_chan.radicand <= radicand;
         do @(posedge clock); while (!req_chan.ready);
         pending_roots.push_back(root_wanted);
      end
      req_chan.valid <= 1'b0;

      // Let the pipeline drain, then keep the receiver running so that any
      // extra root transaction shows up as unexpected.
      gap = 0;
      while (pending_roots.size() != 0 && gap < DRAIN_LIMIT) begin
         @(posedge clock);
         gap++;
      end
      if (pending_roots.size() != 0) begin
         error_count++;
         $display("%0t: %0d root transactions never arrived",
                  $realtime, pending_roots.size());
      end
      repeat (3 * PIPE_LATENCY) @(posedge clock);

      $display("Covered %0d directed and %0d random radicands, %0d roots checked.",
               DIRECTED_COUNT, random_sent, roots_checked);
      $display("Input held off by back-pressure for %0d cycles, %0d errors.",
               input_stall_cycles, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Receiver. It checks each accepted root and then chooses the next ready
   // value. Random stall bursts come and go until the quiet tail; once a few
   // hundred roots are in, it holds ready low for a long stretch so that the
   // pipeline fills and pushes back on the radicand channel.
   initial begin : root_receiver
      int stall_left;
      bit long_hold_done;
      stall_left     = 0;
      long_hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (req_chan.valid && !req_chan.ready) begin
            input_stall_cycles++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_root(rsp_chan.root);
         end

         if (!long_hold_done && roots_checked >= HOLD_AFTER) begin
            stall_left     = HOLD_CYCLES;
            long_hold_done = 1'b1;
         end

         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(1, 18) - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Watchdog, far beyond the slowest legal run of this stimulus.
   initial begin : watchdog
      #2_000_000;
      $display("Timeout with %0d roots still outstanding", pending_roots.size());
      $display("Verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/isqrt_pkg.sv
hdl/isqrt_if.sv
hdl/isqrt_stage.sv
hdl/integer_square_root_48bit.sv
verif/tb_top.sv
